@@ rtl/pps_pkg.sv @@
// Shared constants, widths and the arctangent table of the projectile pitch solver.
// Used by every module of the solver but pps_mul; depends on nothing else.
package pps_pkg;

    // Number of CORDIC rotations; more than 32 acts as 32.
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_CELLS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    // Cell counts of the two square roots and of the time divider.
    localparam int SQ1_CELLS = 45;
    localparam int SQ2_CELLS = 62;
    localparam int DIV_CELLS = 20;

    // The pitch result waits this many stages to meet the flight time.
    localparam int PITCH_DLY  = SQ2_CELLS + DIV_CELLS + 2 - CORDIC_CELLS;
    localparam int PIPE_DEPTH = 13 + SQ1_CELLS + SQ2_CELLS + DIV_CELLS;

    // Square root cell widths: radicand, partial remainder, root.
    localparam int SQ_RAD_W  = 128;
    localparam int SQ_REM_W  = 66;
    localparam int SQ_ROOT_W = 64;

    // CORDIC vector and angle widths.
    localparam int CX_W = 43;
    localparam int CZ_W = 34;

    // Divider remainder width and quotient width.
    localparam int DIV_W = 108;
    localparam int QT_W  = 20;

    localparam logic [14:0] G_RESET      = 15'd9783;
    localparam logic [13:0] W_SCALE      = 14'd15625;
    localparam logic [9:0]  T_SCALE      = 10'd1000;
    localparam logic [17:0] PITCH_MAX    = 18'd25736;
    localparam logic [19:0] TIME_MAX     = 20'hFFFFF;
    localparam logic [CZ_W-1:0] ROUND_HALF = CZ_W'(32768);

    // Arctangent of 2^-idx in radians times 2^30.
    function automatic logic signed [CZ_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CZ_W-1:0] v;
        unique case (idx)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            5'd24: v = 34'sd64;
            5'd25: v = 34'sd32;
            5'd26: v = 34'sd16;
            5'd27: v = 34'sd8;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            5'd30: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/pps_mul.sv @@
// Two-stage 64 x 64 bit multiplier built from four 32 x 32 bit partial products.
// Depends on nothing; used by the solver top level.
module pps_mul (
    input  logic         aclk,
    input  logic         en,
    input  logic [63:0]  a_i,
    input  logic [63:0]  b_i,
    output logic [127:0] p_o
);

    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic [127:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= a_i[31:0]  * b_i[31:0];
            lh_reg <= a_i[31:0]  * b_i[63:32];
            hl_reg <= a_i[63:32] * b_i[31:0];
            hh_reg <= a_i[63:32] * b_i[63:32];
            p_reg  <= {64'b0, ll_reg} + {32'b0, lh_reg, 32'b0}
                    + {32'b0, hl_reg, 32'b0} + {hh_reg, 64'b0};
        end
    end

    assign p_o = p_reg;

endmodule

@@ rtl/pps_sqrt_cell.sv @@
// One cell of the digit-by-digit square root chain: one root bit per cell.
// Depends on pps_pkg.
module pps_sqrt_cell (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [pps_pkg::SQ_RAD_W-1:0]   rad_i,
    input  logic [pps_pkg::SQ_REM_W-1:0]   rem_i,
    input  logic [pps_pkg::SQ_ROOT_W-1:0]  root_i,
    output logic [pps_pkg::SQ_RAD_W-1:0]   rad_o,
    output logic [pps_pkg::SQ_REM_W-1:0]   rem_o,
    output logic [pps_pkg::SQ_ROOT_W-1:0]  root_o
);
    import pps_pkg::*;

    logic [SQ_RAD_W-1:0]  rad_reg;
    logic [SQ_REM_W-1:0]  rem_reg;
    logic [SQ_ROOT_W-1:0] root_reg;
    logic [SQ_REM_W-1:0]  rem_sh, trial;
    logic                 fits;

    // Bring down the next two radicand bits and try a one in the next root bit.
    always_comb begin
        rem_sh = {rem_i[SQ_REM_W-3:0], rad_i[SQ_RAD_W-1:SQ_RAD_W-2]};
        trial  = {root_i, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= {rad_i[SQ_RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_i[SQ_ROOT_W-2:0], fits};
        end
    end

    assign rad_o  = rad_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;

endmodule

@@ rtl/pps_cordic_cell.sv @@
// One vectoring CORDIC rotation; the cell's position sets its shift and angle.
// Depends on pps_pkg for widths and the arctangent table.
module pps_cordic_cell (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [4:0]                       step,
    input  logic signed [pps_pkg::CX_W-1:0]  x_i,
    input  logic signed [pps_pkg::CX_W-1:0]  y_i,
    input  logic signed [pps_pkg::CZ_W-1:0]  z_i,
    output logic signed [pps_pkg::CX_W-1:0]  x_o,
    output logic signed [pps_pkg::CX_W-1:0]  y_o,
    output logic signed [pps_pkg::CZ_W-1:0]  z_o
);
    import pps_pkg::*;

    logic signed [CX_W-1:0] x_reg, y_reg, xs, ys;
    logic signed [CZ_W-1:0] z_reg, ang;

    always_comb begin
        xs  = x_i >>> step;
        ys  = y_i >>> step;
        ang = atan_q30(step);
    end

    // Rotate toward the x axis; a non-negative y rotates clockwise.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (!y_i[CX_W-1]) begin
                x_reg <= x_i + ys;
                y_reg <= y_i - xs;
                z_reg <= z_i + ang;
            end else begin
                x_reg <= x_i - ys;
                y_reg <= y_i + xs;
                z_reg <= z_i - ang;
            end
        end
    end

    assign x_o = x_reg;
    assign y_o = y_reg;
    assign z_o = z_reg;

endmodule

@@ rtl/pps_div_cell.sv @@
// One restoring division cell: one quotient bit per cell, divisor halves each cell.
// Depends on pps_pkg.
module pps_div_cell (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [pps_pkg::DIV_W-1:0]   num_i,
    input  logic [pps_pkg::DIV_W-1:0]   dvs_i,
    input  logic [pps_pkg::QT_W-1:0]    quo_i,
    output logic [pps_pkg::DIV_W-1:0]   num_o,
    output logic [pps_pkg::DIV_W-1:0]   dvs_o,
    output logic [pps_pkg::QT_W-1:0]    quo_o
);
    import pps_pkg::*;

    logic [DIV_W-1:0] num_reg, dvs_reg;
    logic [QT_W-1:0]  quo_reg;
    logic             fits;

    assign fits = (num_i >= dvs_i);

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= fits ? (num_i - dvs_i) : num_i;
            dvs_reg <= {1'b0, dvs_i[DIV_W-1:1]};
            quo_reg <= {quo_i[QT_W-2:0], fits};
        end
    end

    assign num_o = num_reg;
    assign dvs_o = dvs_reg;
    assign quo_o = quo_reg;

endmodule

@@ rtl/projectile_pitch_solver.sv @@
// Drag-free launch pitch solver, top level. Depends on pps_pkg, pps_mul,
// pps_sqrt_cell, pps_cordic_cell and pps_div_cell.
// Data passes the 45-cell and 62-cell square roots, then the 20-cell divider.
// Throughput: one item per cycle; the whole pipeline stalls only while a result
// waits at the output. Reset (aresetn low, synchronous) empties the pipeline and
// loads the gravity register with 9783 mm/s^2.
module projectile_pitch_solver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,   // gravity_mm_s2
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,       // muzzle_speed[14:0], distance_mm[30:15],
                                       // height_mm[46:31], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // pitch_angle[15:0], flight_time[35:16], zero fill
    output logic        m_tuser        // no_solution
);
    import pps_pkg::*;

    // Sideband that rides beside the first square root chain. At the stages
    // before the discriminant is known, nosol only marks zero speed or distance.
    typedef struct packed {
        logic [43:0] w;
        logic [56:0] np;
        logic [60:0] hw;
        logic [14:0] s;
        logic [15:0] d;
        logic        hneg;
        logic        nosol;
    } sq1_sb_t;

    // Sideband beside the second square root chain.
    typedef struct packed {
        logic [15:0] d;
        logic [86:0] dt;
        logic        nosol;
    } sq2_sb_t;

    // Sideband beside the divider.
    typedef struct packed {
        logic sat;
        logic nosol;
    } div_sb_t;

    // ------------------------------------------------------------------
    // Flow control: every stage moves together. The output register takes
    // a new result whenever it is empty or being read, and in that same
    // cycle the input side takes a new item.
    // ------------------------------------------------------------------
    logic                  adv;
    logic                  m_tvalid_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [14:0]           gravity_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= G_RESET;
        end else if (cfg_wr_en) begin
            gravity_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage A: capture the item, take the height apart into sign and
    // magnitude, and scale gravity by 1024.
    // ------------------------------------------------------------------
    logic [14:0] in_s;
    logic [15:0] in_d, in_h, in_hmag;

    assign in_s    = s_tdata[14:0];
    assign in_d    = s_tdata[30:15];
    assign in_h    = s_tdata[46:31];
    assign in_hmag = in_h[15] ? (~in_h + 16'd1) : in_h;

    logic [14:0] a_s_reg;
    logic [15:0] a_d_reg, a_hmag_reg;
    logic        a_hneg_reg, a_zero_reg;
    logic [24:0] a_gk_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_s_reg    <= in_s;
            a_d_reg    <= in_d;
            a_hmag_reg <= in_hmag;
            a_hneg_reg <= in_h[15];
            a_zero_reg <= (in_s == '0) || (in_d == '0);
            a_gk_reg   <= {gravity_reg, 10'b0};
        end
    end

    // ------------------------------------------------------------------
    // Stage B: s^2, g*d and 2*g*|h|, all narrow products.
    // ------------------------------------------------------------------
    logic [29:0] b_ss_reg;
    logic [40:0] b_gd_reg;
    logic [41:0] b_t2_reg;
    logic [14:0] b_s_reg;
    logic [15:0] b_d_reg, b_hmag_reg;
    logic        b_hneg_reg, b_zero_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_ss_reg   <= 30'(a_s_reg) * 30'(a_s_reg);
            b_gd_reg   <= 41'(a_gk_reg) * 41'(a_d_reg);
            b_t2_reg   <= 42'({a_gk_reg, 1'b0}) * 42'(a_hmag_reg);
            b_s_reg    <= a_s_reg;
            b_d_reg    <= a_d_reg;
            b_hmag_reg <= a_hmag_reg;
            b_hneg_reg <= a_hneg_reg;
            b_zero_reg <= a_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: W = 15625*s^2 (speed squared in mm^2/s^2 times 1024) and
    // the positive part g*d^2 of the tangent's numerator.
    // ------------------------------------------------------------------
    logic [43:0] c_w_reg;
    logic [56:0] c_np_reg;
    logic [40:0] c_gd_reg;
    logic [41:0] c_t2_reg;
    logic [14:0] c_s_reg;
    logic [15:0] c_d_reg, c_hmag_reg;
    logic        c_hneg_reg, c_zero_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_w_reg    <= 44'(W_SCALE) * 44'(b_ss_reg);
            c_np_reg   <= 57'(b_gd_reg) * 57'(b_d_reg);
            c_gd_reg   <= b_gd_reg;
            c_t2_reg   <= b_t2_reg;
            c_s_reg    <= b_s_reg;
            c_d_reg    <= b_d_reg;
            c_hmag_reg <= b_hmag_reg;
            c_hneg_reg <= b_hneg_reg;
            c_zero_reg <= b_zero_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages D and E: the wide products W^2, (g*d)^2 and 2*g*|h|*W in
    // two-stage multipliers; 2*|h|*W is formed beside them.
    // ------------------------------------------------------------------
    logic [127:0] p_ww, p_gg, p_tw;

    pps_mul u_mul_ww (.aclk, .en(adv), .a_i(64'(c_w_reg)),  .b_i(64'(c_w_reg)),  .p_o(p_ww));
    pps_mul u_mul_gg (.aclk, .en(adv), .a_i(64'(c_gd_reg)), .b_i(64'(c_gd_reg)), .p_o(p_gg));
    pps_mul u_mul_tw (.aclk, .en(adv), .a_i(64'(c_t2_reg)), .b_i(64'(c_w_reg)),  .p_o(p_tw));

    sq1_sb_t d_sb_reg, e_sb_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_sb_reg.w     <= c_w_reg;
            d_sb_reg.np    <= c_np_reg;
            d_sb_reg.hw    <= 61'({c_hmag_reg, 1'b0}) * 61'(c_w_reg);
            d_sb_reg.s     <= c_s_reg;
            d_sb_reg.d     <= c_d_reg;
            d_sb_reg.hneg  <= c_hneg_reg;
            d_sb_reg.nosol <= c_zero_reg;
            e_sb_reg       <= d_sb_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: the discriminant, kept as a sum of positive and negative
    // parts so that its sign is a plain compare. A negative discriminant
    // makes the target unreachable.
    // ------------------------------------------------------------------
    logic [88:0] f_pos, f_neg, f_q_reg;
    sq1_sb_t     f_sb_reg, f_sb_next;

    always_comb begin
        f_pos = 89'(p_ww) + (e_sb_reg.hneg ? 89'(p_tw) : 89'd0);
        f_neg = 89'(p_gg) + (e_sb_reg.hneg ? 89'd0 : 89'(p_tw));
        f_sb_next       = e_sb_reg;
        f_sb_next.nosol = e_sb_reg.nosol || (f_pos < f_neg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_q_reg  <= f_pos - f_neg;
            f_sb_reg <= f_sb_next;
        end
    end

    // ------------------------------------------------------------------
    // First square root chain: r = floor(sqrt(Q)), one root bit per cell.
    // The 89-bit discriminant is placed below one zero bit at the top of the
    // radicand so that 45 cells consume exactly its bits and that zero.
    // ------------------------------------------------------------------
    logic [SQ_RAD_W-1:0]  sq1_rad  [SQ1_CELLS+1];
    logic [SQ_REM_W-1:0]  sq1_rem  [SQ1_CELLS+1];
    logic [SQ_ROOT_W-1:0] sq1_root [SQ1_CELLS+1];
    sq1_sb_t              sq1_dly  [SQ1_CELLS];

    assign sq1_rad[0]  = {1'b0, f_q_reg, 38'b0};
    assign sq1_rem[0]  = '0;
    assign sq1_root[0] = '0;

    for (genvar gi = 0; gi < SQ1_CELLS; gi++) begin : g_sq1
        pps_sqrt_cell u_cell (
            .aclk,
            .en     (adv),
            .rad_i  (sq1_rad[gi]),
            .rem_i  (sq1_rem[gi]),
            .root_i (sq1_root[gi]),
            .rad_o  (sq1_rad[gi+1]),
            .rem_o  (sq1_rem[gi+1]),
            .root_o (sq1_root[gi+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq1_dly[0] <= f_sb_reg;
            for (int k = 1; k < SQ1_CELLS; k++) begin
                sq1_dly[k] <= sq1_dly[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage H: W + r for the denominator, the signed numerator
    // g*d^2 + 2*h*W as magnitude and sign, and 1000*s for the time.
    // ------------------------------------------------------------------
    sq1_sb_t     g_sb;
    logic [44:0] g_r;

    assign g_sb = sq1_dly[SQ1_CELLS-1];
    assign g_r  = sq1_root[SQ1_CELLS][44:0];

    logic [45:0] h_wr_reg;
    logic [61:0] h_mag_reg;
    logic        h_nneg_reg, h_nosol_reg;
    logic [24:0] h_s1000_reg;
    logic [15:0] h_d_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            h_wr_reg <= 46'(g_sb.w) + 46'(g_r);
            if (!g_sb.hneg) begin
                h_mag_reg  <= 62'(g_sb.np) + 62'(g_sb.hw);
                h_nneg_reg <= 1'b0;
            end else if (61'(g_sb.np) >= g_sb.hw) begin
                h_mag_reg  <= 62'(61'(g_sb.np) - g_sb.hw);
                h_nneg_reg <= 1'b0;
            end else begin
                h_mag_reg  <= 62'(g_sb.hw - 61'(g_sb.np));
                h_nneg_reg <= 1'b1;
            end
            h_s1000_reg <= 25'(T_SCALE) * 25'(g_sb.s);
            h_d_reg     <= g_sb.d;
            h_nosol_reg <= g_sb.nosol;
        end
    end

    // ------------------------------------------------------------------
    // Stage I: the denominator d*(W + r) of the lower root's tangent.
    // ------------------------------------------------------------------
    logic [61:0] i_den_reg, i_mag_reg;
    logic        i_nneg_reg, i_nosol_reg;
    logic [24:0] i_s1000_reg;
    logic [15:0] i_d_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            i_den_reg   <= 62'(h_d_reg) * 62'(h_wr_reg);
            i_mag_reg   <= h_mag_reg;
            i_nneg_reg  <= h_nneg_reg;
            i_s1000_reg <= h_s1000_reg;
            i_d_reg     <= h_d_reg;
            i_nosol_reg <= h_nosol_reg;
        end
    end

    // ------------------------------------------------------------------
    // Pitch branch. Stage J finds the leading one of (den | mag); stage K
    // shifts both so that the larger lies in [2^39, 2^40), dropping low
    // bits on a right shift. The CORDIC cells then rotate the vector.
    // ------------------------------------------------------------------
    logic [61:0] j_or;
    logic [5:0]  j_msb;

    assign j_or = i_den_reg | i_mag_reg;

    always_comb begin
        j_msb = '0;
        for (int k = 0; k < 62; k++) begin
            if (j_or[k]) begin
                j_msb = 6'(k);
            end
        end
    end

    logic [5:0]  j_pos_reg;
    logic [61:0] j_den_reg, j_mag_reg;
    logic        j_nneg_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            j_pos_reg  <= j_msb;
            j_den_reg  <= i_den_reg;
            j_mag_reg  <= i_mag_reg;
            j_nneg_reg <= i_nneg_reg;
        end
    end

    logic [61:0] k_xs, k_ys;

    always_comb begin
        if (j_pos_reg > 6'd39) begin
            k_xs = j_den_reg >> (j_pos_reg - 6'd39);
            k_ys = j_mag_reg >> (j_pos_reg - 6'd39);
        end else begin
            k_xs = j_den_reg << (6'd39 - j_pos_reg);
            k_ys = j_mag_reg << (6'd39 - j_pos_reg);
        end
    end

    logic signed [CX_W-1:0] cx [CORDIC_CELLS+1];
    logic signed [CX_W-1:0] cy [CORDIC_CELLS+1];
    logic signed [CZ_W-1:0] cz [CORDIC_CELLS+1];
    logic signed [CX_W-1:0] k_x_reg, k_y_reg;
    logic                   k_nneg_reg;
    logic                   cn_dly [CORDIC_CELLS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            k_x_reg    <= {1'b0, k_xs[CX_W-2:0]};
            k_y_reg    <= {1'b0, k_ys[CX_W-2:0]};
            k_nneg_reg <= j_nneg_reg;
        end
    end

    assign cx[0] = k_x_reg;
    assign cy[0] = k_y_reg;
    assign cz[0] = '0;

    for (genvar gc = 0; gc < CORDIC_CELLS; gc++) begin : g_cordic
        pps_cordic_cell u_cell (
            .aclk,
            .en   (adv),
            .step (5'(gc)),
            .x_i  (cx[gc]),
            .y_i  (cy[gc]),
            .z_i  (cz[gc]),
            .x_o  (cx[gc+1]),
            .y_o  (cy[gc+1]),
            .z_o  (cz[gc+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cn_dly[0] <= k_nneg_reg;
            for (int k = 1; k < CORDIC_CELLS; k++) begin
                cn_dly[k] <= cn_dly[k-1];
            end
        end
    end

    // Angle: negative clamps to zero, then round half up from 2^30 to
    // 2^14 scale, clamp at the largest pitch and apply the numerator sign.
    logic [CZ_W-1:0] pz_pos, pz_sum;
    logic [17:0]     pz_p, pz_cl;
    logic [15:0]     p_pitch_reg;
    logic [15:0]     pt_dly [PITCH_DLY];

    always_comb begin
        pz_pos = cz[CORDIC_CELLS][CZ_W-1] ? '0 : cz[CORDIC_CELLS];
        pz_sum = pz_pos + ROUND_HALF;
        pz_p   = pz_sum[CZ_W-1:16];
        pz_cl  = (pz_p > PITCH_MAX) ? PITCH_MAX : pz_p;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_pitch_reg <= cn_dly[CORDIC_CELLS-1] ? (16'd0 - pz_cl[15:0]) : pz_cl[15:0];
            pt_dly[0]   <= p_pitch_reg;
            for (int k = 1; k < PITCH_DLY; k++) begin
                pt_dly[k] <= pt_dly[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Time branch. Stages J and K form mag^2, den^2 and 1000*s*den;
    // stage L adds the squares for the second square root.
    // ------------------------------------------------------------------
    logic [127:0] p_mm, p_dd, p_dt;

    pps_mul u_mul_mm (.aclk, .en(adv), .a_i(64'(i_mag_reg)),   .b_i(64'(i_mag_reg)), .p_o(p_mm));
    pps_mul u_mul_dd (.aclk, .en(adv), .a_i(64'(i_den_reg)),   .b_i(64'(i_den_reg)), .p_o(p_dd));
    pps_mul u_mul_dt (.aclk, .en(adv), .a_i(64'(i_s1000_reg)), .b_i(64'(i_den_reg)), .p_o(p_dt));

    logic [15:0]  tj_d_reg, tk_d_reg, l_d_reg;
    logic         tj_nosol_reg, tk_nosol_reg, l_nosol_reg;
    logic [123:0] l_sum_reg;
    logic [86:0]  l_dt_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            tj_d_reg     <= i_d_reg;
            tj_nosol_reg <= i_nosol_reg;
            tk_d_reg     <= tj_d_reg;
            tk_nosol_reg <= tj_nosol_reg;
            l_sum_reg    <= p_mm[123:0] + p_dd[123:0];
            l_dt_reg     <= p_dt[86:0];
            l_d_reg      <= tk_d_reg;
            l_nosol_reg  <= tk_nosol_reg;
        end
    end

    // Second square root chain: M = floor(sqrt(mag^2 + den^2)).
    logic [SQ_RAD_W-1:0]  sq2_rad  [SQ2_CELLS+1];
    logic [SQ_REM_W-1:0]  sq2_rem  [SQ2_CELLS+1];
    logic [SQ_ROOT_W-1:0] sq2_root [SQ2_CELLS+1];
    sq2_sb_t              sq2_dly  [SQ2_CELLS];

    assign sq2_rad[0]  = {l_sum_reg, 4'b0};
    assign sq2_rem[0]  = '0;
    assign sq2_root[0] = '0;

    for (genvar gj = 0; gj < SQ2_CELLS; gj++) begin : g_sq2
        pps_sqrt_cell u_cell (
            .aclk,
            .en     (adv),
            .rad_i  (sq2_rad[gj]),
            .rem_i  (sq2_rem[gj]),
            .root_i (sq2_root[gj]),
            .rad_o  (sq2_rad[gj+1]),
            .rem_o  (sq2_rem[gj+1]),
            .root_o (sq2_root[gj+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq2_dly[0].d     <= l_d_reg;
            sq2_dly[0].dt    <= l_dt_reg;
            sq2_dly[0].nosol <= l_nosol_reg;
            for (int k = 1; k < SQ2_CELLS; k++) begin
                sq2_dly[k] <= sq2_dly[k-1];
            end
        end
    end

    // Stage X: time numerator M*d*2^24. Stage Y: saturation test and the
    // divider's starting divisor 1000*s*den*2^19.
    sq2_sb_t     x_in;
    logic [77:0] x_prod;

    assign x_in   = sq2_dly[SQ2_CELLS-1];
    assign x_prod = 78'(sq2_root[SQ2_CELLS][61:0]) * 78'(x_in.d);

    logic [101:0]     x_nt_reg;
    logic [86:0]      x_dt_reg;
    logic             x_nosol_reg;
    logic [DIV_W-1:0] y_num_reg, y_dvs_reg;
    div_sb_t          y_sb_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_nt_reg       <= {x_prod, 24'b0};
            x_dt_reg       <= x_in.dt;
            x_nosol_reg    <= x_in.nosol;
            y_num_reg      <= {6'b0, x_nt_reg};
            y_dvs_reg      <= {2'b0, x_dt_reg, 19'b0};
            y_sb_reg.sat   <= ({6'b0, x_nt_reg} >= {1'b0, x_dt_reg, 20'b0});
            y_sb_reg.nosol <= x_nosol_reg;
        end
    end

    // Divider chain: 20 quotient bits, most significant first.
    logic [DIV_W-1:0] dv_num [DIV_CELLS+1];
    logic [DIV_W-1:0] dv_dvs [DIV_CELLS+1];
    logic [QT_W-1:0]  dv_quo [DIV_CELLS+1];
    div_sb_t          dv_dly [DIV_CELLS];

    assign dv_num[0] = y_num_reg;
    assign dv_dvs[0] = y_dvs_reg;
    assign dv_quo[0] = '0;

    for (genvar gk = 0; gk < DIV_CELLS; gk++) begin : g_div
        pps_div_cell u_cell (
            .aclk,
            .en    (adv),
            .num_i (dv_num[gk]),
            .dvs_i (dv_dvs[gk]),
            .quo_i (dv_quo[gk]),
            .num_o (dv_num[gk+1]),
            .dvs_o (dv_dvs[gk+1]),
            .quo_o (dv_quo[gk+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_dly[0] <= y_sb_reg;
            for (int k = 1; k < DIV_CELLS; k++) begin
                dv_dly[k] <= dv_dly[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register. An unreachable target or a zero speed or distance
    // reports no_solution with pitch and time forced to zero.
    // ------------------------------------------------------------------
    div_sb_t     o_sb;
    logic [15:0] pitch_reg;
    logic [19:0] time_reg;
    logic        nosol_reg;

    assign o_sb = dv_dly[DIV_CELLS-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            nosol_reg <= o_sb.nosol;
            pitch_reg <= o_sb.nosol ? 16'd0 : pt_dly[PITCH_DLY-1];
            time_reg  <= o_sb.nosol ? 20'd0 :
                         (o_sb.sat ? TIME_MAX : dv_quo[DIV_CELLS]);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = nosol_reg;
    assign m_tdata  = {4'b0, time_reg, pitch_reg};

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    a_nosol_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("no_solution item carries nonzero pitch or time");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |->
            (($signed(m_tdata[15:0]) <= 16'sd25736) && ($signed(m_tdata[15:0]) >= -16'sd25736)))
        else $error("pitch outside its clamp range");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while the output was stalled");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted item did not enter the pipeline");

endmodule
